### sv/order_crossing_engine_unit_defines.svh
// assertion macros for the order crossing engine
`ifndef ORDER_CROSSING_ENGINE_UNIT_DEFINES_SVH
`define ORDER_CROSSING_ENGINE_UNIT_DEFINES_SVH

// concurrent check on a given clock and active-low reset
`define OCE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the block clock and reset
`define OCE_ASSERT(lbl, prop, msg) \
  `OCE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### sv/oce_pkg.sv
// types and codes shared by the order crossing engine
package oce_pkg;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_SUBMIT = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned MaxResults = 64;

  typedef enum logic [2:0] {
    ST_MORE      = 3'd0,
    ST_FILLED    = 3'd1,
    ST_PARTIAL   = 3'd2,
    ST_RESTING   = 3'd3,
    ST_BAD_QTY   = 3'd4,
    ST_BAD_LIMIT = 3'd5,
    ST_NO_LIQ    = 3'd6,
    ST_FULL      = 3'd7
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic        side;
    logic        order_type;
    logic [7:0]  symbol;
    logic [15:0] order_id;
    logic [23:0] quantity;
    logic [23:0] price;
    logic [2:0]  level;
    logic [23:0] level_size;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_order_id;
    logic [7:0]  out_symbol;
    logic        has_fill;
    logic [23:0] fill_price;
    logic [23:0] fill_qty;
    logic [2:0]  status;
    logic [23:0] filled_total;
    logic [47:0] notional_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] price;
    logic [23:0] size;
  } book_ent_t;

  typedef struct packed {
    logic        side;
    logic [7:0]  symbol;
    logic [15:0] order_id;
    logic [23:0] limit;
    logic [23:0] quantity;
    logic [23:0] filled;
    logic [47:0] notional;
  } rest_ent_t;

endpackage

### sv/order_crossing_engine_unit.sv
// order crossing engine: book snapshot, resting order table and crossing sequencer
//
// input channel in_valid_i/in_ready_o carries one in_item_t per transfer; output
// channel out_valid_o/out_ready_i carries one out_item_t per transfer.
// in_ready_o is high only while the sequencer is idle: one item is worked at a time.
// a book level load gives no result. a rejected order gives its single result from
// the reject state once the output register is free. crossing visits one book level
// at a time in the steps ram read, evaluate, multiply and accumulate; evaluate waits
// while a fill is pending and the output register is busy. a book update reads each
// resting slot (read, evaluate), crosses matching orders as above and, when an order
// leaves the table, compacts the later slots one slot at a time; at most 64 results.
// the book and the table live in two rams with registered read.
// reset empties both book sides (per-entry valid flops) and the table (fill count);
// no clearing pass is needed. a result waits in the output register while the
// receiver stalls and the sequencer holds until that register is free.
module order_crossing_engine_unit #(
  parameter int unsigned BOOK_DEPTH = 8,
  parameter int unsigned REST_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  oce_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output oce_pkg::out_item_t out_data_o
);
  import oce_pkg::*;

  `include "order_crossing_engine_unit_defines.svh"

  localparam int unsigned BW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(BOOK_DEPTH + 1);
  localparam int unsigned BookRamDepth = 2 * (1 << BW);
  localparam int unsigned SW = (REST_SLOTS > 1) ? $clog2(REST_SLOTS) : 1;
  localparam int unsigned CW = $clog2(REST_SLOTS + 1);
  localparam int unsigned RestRamDepth = 1 << SW;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_REJ  = 11'b00000000010,
    S_XRD  = 11'b00000000100,
    S_XEV  = 11'b00000001000,
    S_MUL  = 11'b00000010000,
    S_ACC  = 11'b00000100000,
    S_END  = 11'b00001000000,
    S_URD  = 11'b00010000000,
    S_UEV  = 11'b00100000000,
    S_CRD  = 11'b01000000000,
    S_CWR  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] id_q, id_d;
  logic [7:0]  sym_q, sym_d;
  logic        sell_q, sell_d;
  logic        lim_en_q, lim_en_d;
  logic [23:0] lim_q, lim_d;
  logic [23:0] qty_q, qty_d;
  logic [23:0] filled_q, filled_d;
  logic [47:0] notional_q, notional_d;
  logic        upd_q, upd_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic        pend_q, pend_d;
  logic [23:0] fp_q, fp_d;
  logic [23:0] fq_q, fq_d;
  logic [47:0] prod_q, prod_d;
  logic [CW-1:0] slot_q, slot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cmp_q, cmp_d;
  logic [6:0]  k_q, k_d;
  status_e     rej_st_q, rej_st_d;
  logic        bvld_q;
  logic [BookRamDepth-1:0] book_vld_q;

  logic        out_valid_q;
  out_item_t   out_q;
  logic        out_load;
  out_item_t   out_item;
  logic        out_free;

  logic                  book_we, book_re;
  logic [BW:0]           book_waddr, book_raddr;
  book_ent_t             book_wdata, book_rdata;
  logic                  rest_we, rest_re;
  logic [SW-1:0]         rest_waddr, rest_raddr;
  rest_ent_t             rest_wdata, rest_rdata;

  logic [BW+2:0] lvl_ext;
  logic [23:0]   lv_p, lv_s, rem, qv;
  logic          stop;
  status_e       fin_st;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign lvl_ext    = {{BW{1'b0}}, in_data_i.level};

  oce_ram #(.WIDTH($bits(book_ent_t)), .DEPTH(BookRamDepth)) u_book (
    .clk_i   (clk_i),
    .we_i    (book_we),
    .waddr_i (book_waddr),
    .wdata_i (book_wdata),
    .re_i    (book_re),
    .raddr_i (book_raddr),
    .rdata_o (book_rdata)
  );

  oce_ram #(.WIDTH($bits(rest_ent_t)), .DEPTH(RestRamDepth)) u_rest (
    .clk_i   (clk_i),
    .we_i    (rest_we),
    .waddr_i (rest_waddr),
    .wdata_i (rest_wdata),
    .re_i    (rest_re),
    .raddr_i (rest_raddr),
    .rdata_o (rest_rdata)
  );

  always_comb begin
    lv_p = book_rdata.price;
    lv_s = bvld_q ? book_rdata.size : 24'd0;
    rem  = qty_q - filled_q;
    qv   = (rem < lv_s) ? rem : lv_s;
    stop = (filled_q >= qty_q) || (lv_s == 24'd0) ||
           (lim_en_q && (sell_q ? (lv_p < lim_q) : (lv_p > lim_q)));
    if (filled_q >= qty_q) begin
      fin_st = ST_FILLED;
    end else if (upd_q) begin
      fin_st = ST_PARTIAL;
    end else if (!lim_en_q) begin
      fin_st = (filled_q != 24'd0) ? ST_PARTIAL : ST_NO_LIQ;
    end else if (cnt_q == CW'(REST_SLOTS)) begin
      fin_st = ST_FULL;
    end else begin
      fin_st = (filled_q != 24'd0) ? ST_PARTIAL : ST_RESTING;
    end
  end

  always_comb begin
    state_d    = state_q;
    id_d       = id_q;
    sym_d      = sym_q;
    sell_d     = sell_q;
    lim_en_d   = lim_en_q;
    lim_d      = lim_q;
    qty_d      = qty_q;
    filled_d   = filled_q;
    notional_d = notional_q;
    upd_d      = upd_q;
    lvl_d      = lvl_q;
    pend_d     = pend_q;
    fp_d       = fp_q;
    fq_d       = fq_q;
    prod_d     = prod_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    cmp_d      = cmp_q;
    k_d        = k_q;
    rej_st_d   = rej_st_q;

    book_we    = 1'b0;
    book_waddr = {in_data_i.side, lvl_ext[BW-1:0]};
    book_wdata = '{price: in_data_i.price, size: in_data_i.level_size};
    book_re    = 1'b0;
    book_raddr = {sell_q, lvl_q[BW-1:0]};

    rest_we    = 1'b0;
    rest_waddr = slot_q[SW-1:0];
    rest_wdata = '{side: sell_q, symbol: sym_q, order_id: id_q, limit: lim_q,
                   quantity: qty_q, filled: filled_q, notional: notional_q};
    rest_re    = 1'b0;
    rest_raddr = slot_q[SW-1:0];

    out_load = 1'b0;
    out_item = '{out_order_id: id_q, out_symbol: sym_q, has_fill: pend_q,
                 fill_price: pend_q ? fp_q : 24'd0, fill_qty: pend_q ? fq_q : 24'd0,
                 status: ST_MORE, filled_total: filled_q, notional_total: notional_q,
                 last: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.mode)
            MODE_LOAD: begin
              book_we = (lvl_ext < (BW + 3)'(BOOK_DEPTH));
            end
            MODE_SUBMIT: begin
              id_d       = in_data_i.order_id;
              sym_d      = in_data_i.symbol;
              sell_d     = in_data_i.side;
              lim_en_d   = in_data_i.order_type;
              lim_d      = in_data_i.price;
              qty_d      = in_data_i.quantity;
              filled_d   = 24'd0;
              notional_d = 48'd0;
              lvl_d      = '0;
              pend_d     = 1'b0;
              upd_d      = 1'b0;
              k_d        = 7'd0;
              if (in_data_i.quantity == 24'd0) begin
                rej_st_d = ST_BAD_QTY;
                state_d  = S_REJ;
              end else if (in_data_i.order_type && in_data_i.price == 24'd0) begin
                rej_st_d = ST_BAD_LIMIT;
                state_d  = S_REJ;
              end else begin
                state_d = S_XRD;
              end
            end
            MODE_UPDATE: begin
              sym_d   = in_data_i.symbol;
              slot_d  = '0;
              k_d     = 7'd0;
              upd_d   = 1'b1;
              state_d = S_URD;
            end
            default: ;
          endcase
        end
      end
      S_REJ: begin
        if (out_free) begin
          out_load = 1'b1;
          out_item = '{out_order_id: id_q, out_symbol: sym_q, has_fill: 1'b0,
                       fill_price: 24'd0, fill_qty: 24'd0, status: rej_st_q,
                       filled_total: 24'd0, notional_total: 48'd0, last: 1'b1};
          state_d  = S_IDLE;
        end
      end
      S_XRD: begin
        if (lvl_q == LW'(BOOK_DEPTH)) begin
          state_d = S_END;
        end else begin
          book_re = 1'b1;
          state_d = S_XEV;
        end
      end
      S_XEV: begin
        if (stop) begin
          state_d = S_END;
        end else if (!pend_q || out_free) begin
          if (pend_q) begin
            out_load = 1'b1;
            k_d      = k_q + 7'd1;
          end
          fp_d     = lv_p;
          fq_d     = qv;
          filled_d = filled_q + qv;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = fp_q * fq_q;
        state_d = S_ACC;
      end
      S_ACC: begin
        notional_d = notional_q + prod_q;
        pend_d     = 1'b1;
        lvl_d      = lvl_q + LW'(1);
        state_d    = S_XRD;
      end
      S_END: begin
        if (upd_q && !pend_q) begin
          slot_d  = slot_q + CW'(1);
          state_d = S_URD;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_item.status = fin_st;
          out_item.last   = 1'b1;
          pend_d        = 1'b0;
          if (upd_q) begin
            k_d = k_q + 7'd1;
            if (fin_st == ST_FILLED) begin
              cmp_d   = slot_q;
              state_d = S_CRD;
            end else begin
              rest_we = 1'b1;
              slot_d  = slot_q + CW'(1);
              state_d = S_URD;
            end
          end else begin
            if (fin_st == ST_PARTIAL || fin_st == ST_RESTING) begin
              if (lim_en_q) begin
                rest_we    = 1'b1;
                rest_waddr = cnt_q[SW-1:0];
                cnt_d      = cnt_q + CW'(1);
              end
            end
            state_d = S_IDLE;
          end
        end
      end
      S_URD: begin
        if (slot_q >= cnt_q) begin
          state_d = S_IDLE;
        end else begin
          rest_re = 1'b1;
          state_d = S_UEV;
        end
      end
      S_UEV: begin
        if (rest_rdata.symbol != sym_q) begin
          slot_d  = slot_q + CW'(1);
          state_d = S_URD;
        end else if ((8'(k_q) + 8'(BOOK_DEPTH)) > 8'(MaxResults)) begin
          state_d = S_IDLE;
        end else begin
          id_d       = rest_rdata.order_id;
          sell_d     = rest_rdata.side;
          lim_en_d   = 1'b1;
          lim_d      = rest_rdata.limit;
          qty_d      = rest_rdata.quantity;
          filled_d   = rest_rdata.filled;
          notional_d = rest_rdata.notional;
          lvl_d      = '0;
          pend_d     = 1'b0;
          state_d    = S_XRD;
        end
      end
      S_CRD: begin
        if (({1'b0, cmp_q} + (CW + 1)'(1)) >= {1'b0, cnt_q}) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_URD;
        end else begin
          rest_re    = 1'b1;
          rest_raddr = SW'(cmp_q + CW'(1));
          state_d    = S_CWR;
        end
      end
      S_CWR: begin
        rest_we    = 1'b1;
        rest_waddr = cmp_q[SW-1:0];
        rest_wdata = rest_rdata;
        cmp_d      = cmp_q + CW'(1);
        state_d    = S_CRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      upd_q       <= 1'b0;
      lvl_q       <= '0;
      pend_q      <= 1'b0;
      slot_q      <= '0;
      cnt_q       <= '0;
      cmp_q       <= '0;
      k_q         <= 7'd0;
      bvld_q      <= 1'b0;
      book_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      upd_q   <= upd_d;
      lvl_q   <= lvl_d;
      pend_q  <= pend_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
      cmp_q   <= cmp_d;
      k_q     <= k_d;
      if (book_re) begin
        bvld_q <= book_vld_q[book_raddr];
      end
      if (book_we) begin
        book_vld_q[book_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_d_reg: begin
      id_q       <= id_d;
      sym_q      <= sym_d;
      sell_q     <= sell_d;
      lim_en_q   <= lim_en_d;
      lim_q      <= lim_d;
      qty_q      <= qty_d;
      filled_q   <= filled_d;
      notional_q <= notional_d;
      fp_q       <= fp_d;
      fq_q       <= fq_d;
      prod_q     <= prod_d;
      rej_st_q   <= rej_st_d;
      if (out_load) begin
        out_q <= out_item;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `OCE_ASSERT(a_cnt_range, cnt_q <= CW'(REST_SLOTS), "resting count beyond table size")
  `OCE_ASSERT(a_out_no_overwrite, out_load |-> (!out_valid_q || out_ready_i), "result lost")
  `OCE_ASSERT(a_k_bound, k_q <= 7'(MaxResults), "update gave more than the result limit")
  `OCE_ASSERT(a_idle_no_pend, (state_q == S_IDLE) |-> !pend_q, "pending fill left in idle")
  `OCE_ASSERT(a_accept_idle, (in_valid_i && in_ready_o) |=> (state_q != S_XEV), "bad start")

endmodule

### sv/oce_ram.sv
// generic single-write, single-read ram with registered read
module oce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### bench/order_crossing_engine_unit_tb.sv
// testbench for the order crossing engine: book loads, order crossing and resting re-cross
module order_crossing_engine_unit_tb;
  import oce_pkg::*;

  localparam int unsigned Depth = 8;
  localparam int unsigned Slots = 8;
  localparam int unsigned StallLimit = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;

  order_crossing_engine_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // shadow book and table
  logic [23:0] ask_px [Depth];
  logic [23:0] ask_sz [Depth];
  logic [23:0] bid_px [Depth];
  logic [23:0] bid_sz [Depth];
  rest_ent_t   resting [$];

  out_item_t   expected_fills [$];
  int          mismatches;
  int          fills_seen;
  int          orders_sent;
  int          idle_cycles;
  bit          quiet;
  bit          timed_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t mk_fill(logic [15:0] id, logic [7:0] sym, logic hf,
                                        logic [23:0] fp, logic [23:0] fq, status_e st,
                                        logic [23:0] ft, logic [47:0] nt, logic lst);
    out_item_t r;
    r.out_order_id = id;  r.out_symbol = sym;  r.has_fill = hf;
    r.fill_price = fp;    r.fill_qty = fq;     r.status = st;
    r.filled_total = ft;  r.notional_total = nt; r.last = lst;
    return r;
  endfunction

  function automatic void add_expected(out_item_t r);
    expected_fills.insert(expected_fills.size(), r);
  endfunction

  // crosses one order against the book, queueing fills; returns the fill count
  function automatic int cross_book(logic [15:0] id, logic [7:0] sym, logic sell,
                                    bit lim_ord, logic [23:0] lim, logic [23:0] qty,
                                    ref logic [23:0] filled, ref logic [47:0] notional);
    int n;
    logic [23:0] p, s, q;
    n = 0;
    for (int i = 0; i < Depth; i++) begin
      p = sell ? bid_px[i] : ask_px[i];
      s = sell ? bid_sz[i] : ask_sz[i];
      if (filled >= qty || s == 0) break;
      if (lim_ord && (sell ? (p < lim) : (p > lim))) break;
      q = (qty - filled) < s ? (qty - filled) : s;
      filled += q;
      notional += 48'(p) * 48'(q);
      add_expected(mk_fill(id, sym, 1'b1, p, q, ST_MORE, filled, notional, 1'b0));
      n++;
    end
    return n;
  endfunction

  function automatic void close_order(status_e st);
    out_item_t r;
    r = expected_fills[$];
    r.status = st;
    r.last = 1'b1;
    expected_fills[$] = r;
  endfunction

  function automatic void predict_crossing(in_item_t it);
    logic [23:0] filled;
    logic [47:0] notional;
    status_e     st;
    int          n, k;
    rest_ent_t   e;
    logic [23:0] rf;
    logic [47:0] rn;
    filled = '0;
    notional = '0;
    if (it.mode == MODE_LOAD) begin
      if (it.side) begin
        bid_px[it.level] = it.price; bid_sz[it.level] = it.level_size;
      end else begin
        ask_px[it.level] = it.price; ask_sz[it.level] = it.level_size;
      end
    end else if (it.mode == MODE_SUBMIT) begin
      if (it.quantity == 0) begin
        add_expected(mk_fill(it.order_id, it.symbol, 0, 0, 0, ST_BAD_QTY, 0, 0, 1));
      end else if (it.order_type && it.price == 0) begin
        add_expected(mk_fill(it.order_id, it.symbol, 0, 0, 0, ST_BAD_LIMIT, 0, 0, 1));
      end else begin
        n = cross_book(it.order_id, it.symbol, it.side, it.order_type, it.price, it.quantity,
                       filled, notional);
        if (filled >= it.quantity) st = ST_FILLED;
        else if (!it.order_type) st = filled != 0 ? ST_PARTIAL : ST_NO_LIQ;
        else if (resting.size() >= Slots) st = ST_FULL;
        else begin
          st = filled != 0 ? ST_PARTIAL : ST_RESTING;
          e.side = it.side; e.symbol = it.symbol; e.order_id = it.order_id;
          e.limit = it.price; e.quantity = it.quantity; e.filled = filled;
          e.notional = notional;
          resting.insert(resting.size(), e);
        end
        if (n == 0)
          add_expected(mk_fill(it.order_id, it.symbol, 0, 0, 0, st, filled, notional, 1));
        else close_order(st);
      end
    end else if (it.mode == MODE_UPDATE) begin
      k = 0;
      for (int i = 0; i < resting.size();) begin
        e = resting[i];
        if (e.symbol != it.symbol) begin
          i++;
          continue;
        end
        if (k + Depth > MaxResults) break;
        rf = e.filled;
        rn = e.notional;
        n = cross_book(e.order_id, e.symbol, e.side, 1'b1, e.limit, e.quantity, rf, rn);
        e.filled = rf;
        e.notional = rn;
        if (n == 0) begin
          i++;
          continue;
        end
        k += n;
        if (e.filled >= e.quantity) begin
          close_order(ST_FILLED);
          resting.delete(i);
        end else begin
          close_order(ST_PARTIAL);
          resting[i] = e;
          i++;
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h (fill %0d)", what, got, want, fills_seen);
    mismatches++;
  endtask

  task automatic send_item(in_item_t it);
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_crossing(it);
    if (it.mode == MODE_SUBMIT) orders_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      fills_seen++;
      if (expected_fills.size() == 0) begin
        report_mismatch("unexpected result", out_data.out_order_id, 64'd0);
      end else begin
        w = expected_fills.pop_front();
        if (out_data.out_order_id != w.out_order_id)
          report_mismatch("order_id", out_data.out_order_id, w.out_order_id);
        if (out_data.out_symbol != w.out_symbol)
          report_mismatch("symbol", out_data.out_symbol, w.out_symbol);
        if (out_data.has_fill != w.has_fill)
          report_mismatch("has_fill", out_data.has_fill, w.has_fill);
        if (out_data.fill_price != w.fill_price)
          report_mismatch("fill_price", out_data.fill_price, w.fill_price);
        if (out_data.fill_qty != w.fill_qty)
          report_mismatch("fill_qty", out_data.fill_qty, w.fill_qty);
        if (out_data.status != w.status)
          report_mismatch("status", out_data.status, w.status);
        if (out_data.filled_total != w.filled_total)
          report_mismatch("filled_total", out_data.filled_total, w.filled_total);
        if (out_data.notional_total != w.notional_total)
          report_mismatch("notional_total", out_data.notional_total, w.notional_total);
        if (out_data.last != w.last)
          report_mismatch("last", out_data.last, w.last);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic [1:0] md, logic sd, logic ot, logic [7:0] sym,
                                       logic [15:0] id, logic [23:0] qty, logic [23:0] px,
                                       logic [2:0] lv, logic [23:0] sz);
    in_item_t it;
    it.mode = md; it.side = sd; it.order_type = ot; it.symbol = sym; it.order_id = id;
    it.quantity = qty; it.price = px; it.level = lv; it.level_size = sz;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.mode = 2'($urandom_range(3));
    it.side = 1'($urandom);
    it.order_type = 1'($urandom);
    it.symbol = 8'($urandom_range(2)) | ($urandom_range(9) == 0 ? 8'hfc : 8'h0);
    it.order_id = 16'($urandom);
    it.quantity = $urandom_range(9) == 0 ? 24'($urandom) : 24'($urandom_range(40));
    it.price = $urandom_range(9) == 0 ? 24'($urandom) : 24'($urandom_range(90, 110));
    it.level = 3'($urandom);
    it.level_size = $urandom_range(7) == 0 ? 24'd0 : 24'($urandom_range(1, 30));
    return it;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_fills.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic load_ladder(int levels);
    for (int i = 0; i < Depth; i++) begin
      send_item(mk_item(MODE_LOAD, 0, 0, 0, 0, 0, 24'(100 + i), 3'(i),
                        i < levels ? 24'($urandom_range(1, 20)) : 24'd0));
      send_item(mk_item(MODE_LOAD, 1, 0, 0, 0, 0, 24'(99 - i), 3'(i),
                        i < levels ? 24'($urandom_range(1, 20)) : 24'd0));
    end
  endtask

  task automatic test_rejects_and_empty_book();
    send_item(mk_item(MODE_SUBMIT, 0, 0, 8'hff, 16'hffff, 0, 24'hffffff, 0, 0));
    send_item(mk_item(MODE_SUBMIT, 1, 1, 8'h00, 16'h0000, 24'd5, 0, 0, 0));
    send_item(mk_item(MODE_SUBMIT, 0, 0, 8'h01, 16'h0001, 24'd5, 0, 0, 0));
    send_item(mk_item(MODE_UNUSED, 1, 1, 8'hff, 16'hffff, 24'hffffff, 24'hffffff, 3'd7,
                      24'hffffff));
  endtask

  task automatic test_crossing_directed();
    load_ladder(Depth);
    send_item(mk_item(MODE_SUBMIT, 0, 0, 8'd1, 16'h0010, 24'hffffff, 0, 0, 0));
    send_item(mk_item(MODE_SUBMIT, 1, 1, 8'd1, 16'h0011, 24'd3, 24'd99, 0, 0));
    send_item(mk_item(MODE_SUBMIT, 0, 1, 8'd1, 16'h0012, 24'd50, 24'd102, 0, 0));
    send_item(mk_item(MODE_SUBMIT, 0, 1, 8'd1, 16'h0013, 24'd9, 24'd50, 0, 0));
    wait_drained();
  endtask

  task automatic test_table_full_and_update();
    for (int i = 0; i < Slots + 2; i++)
      send_item(mk_item(MODE_SUBMIT, 1, 1, 8'(i % 2), 16'(16'h0100 + i), 24'd7,
                        24'hffffff, 0, 0));
    send_item(mk_item(MODE_LOAD, 1, 0, 0, 0, 0, 24'hffffff, 3'd0, 24'hffffff));
    send_item(mk_item(MODE_UPDATE, 0, 0, 8'd0, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_UPDATE, 0, 0, 8'd1, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random_flow(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(15) == 0) begin
        load_ladder($urandom_range(Depth));
        sent += 2 * Depth;
      end else begin
        send_item(rand_item());
        sent++;
      end
      if (sent > count / 2 && sent < count / 2 + 25) quiet = 1'b1;
      else quiet = 1'b0;
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatches = 0;
    fills_seen = 0;
    orders_sent = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    timed_out = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      ask_px[i] = '0; ask_sz[i] = '0; bid_px[i] = '0; bid_sz[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_rejects_and_empty_book();
    test_crossing_directed();
    test_table_full_and_update();
    test_random_flow(95);
    wait_drained();
    $display("covered %0d orders with %0d results, book loads, updates and a full table",
             orders_sent, fills_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
